FILE: rtl/core/broadcast_offset_generator_defines.svh
// assertion macros for the broadcast offset generator
`ifndef BROADCAST_OFFSET_GENERATOR_DEFINES_SVH
`define BROADCAST_OFFSET_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BOG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BOG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bog_pkg.sv
// shared types and constants of the broadcast offset generator
package bog_pkg;

  localparam int IDX_W   = 32;
  localparam int OFF_W   = 32;
  localparam int RANK_W  = 3;
  localparam int RANK_CW = 4;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_OUT_RANK  = 3'd0,
    CFG_OUT_EXT   = 3'd1,
    CFG_LEFT_RANK = 3'd2,
    CFG_LEFT_EXT  = 3'd3,
    CFG_RIGHT_RANK = 3'd4,
    CFG_RIGHT_EXT = 3'd5
  } cfg_reg_e;

  // per-axis strides, output stride saturated at 2**32
  typedef struct packed {
    logic [IDX_W:0]   os;
    logic [OFF_W-1:0] ls;
    logic [OFF_W-1:0] rs;
  } bog_stride_t;

  typedef struct packed {
    logic [IDX_W-1:0] rem;
    logic [OFF_W-1:0] loff;
    logic [OFF_W-1:0] roff;
    logic             fault;
  } bog_item_t;

  typedef struct packed {
    logic           busy;
    logic           fault;
    logic [IDX_W:0] limit;
  } bog_status_t;

endpackage

FILE: rtl/core/broadcast_offset_generator.sv
// broadcast offset generator top level: configuration block and chain of divider cells
// Takes one flat output index per clock and returns the left and right operand offsets
// through a pipeline of MAX_RANK*EXTENT_BITS registered cells, one result per clock, and
// a stalled output holds the whole chain. Each cell resolves one coordinate bit by a
// compare and subtract against the axis stride. After reset and after every configuration
// write the strides are rebuilt axis by axis, which holds off input transactions until
// the last axis is written.
module broadcast_offset_generator import bog_pkg::*; #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IDX_W-1:0]  flat_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OFF_W-1:0]  lhs_off_o,
  output logic [OFF_W-1:0]  rhs_off_o,
  output logic              fault_o
);

  localparam int NC = MAX_RANK * EXTENT_BITS;

  bog_stride_t stride [MAX_RANK];
  bog_status_t status;
  logic        vld [NC+1];
  logic        rdy [NC+1];
  bog_item_t   itm [NC+1];

  bog_cfg #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stride_o    (stride),
    .status_o    (status)
  );

  assign vld[0]       = in_valid_i && !status.busy;
  assign in_ready_o   = rdy[0] && !status.busy;
  assign itm[0].rem   = flat_index_i;
  assign itm[0].loff  = '0;
  assign itm[0].roff  = '0;
  assign itm[0].fault = status.fault || ({1'b0, flat_index_i} >= status.limit);

  for (genvar i = 0; i < NC; i++) begin : g_cell
    bog_cell #(
      .SHIFT (EXTENT_BITS - 1 - (i % EXTENT_BITS))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .stride_i (stride[i / EXTENT_BITS]),
      .valid_i  (vld[i]),
      .ready_o  (rdy[i]),
      .item_i   (itm[i]),
      .valid_o  (vld[i+1]),
      .ready_i  (rdy[i+1]),
      .item_o   (itm[i+1])
    );
  end

  assign rdy[NC]     = out_ready_i;
  assign out_valid_o = vld[NC];
  assign fault_o     = itm[NC].fault;
  assign lhs_off_o   = itm[NC].fault ? '0 : itm[NC].loff;
  assign rhs_off_o   = itm[NC].fault ? '0 : itm[NC].roff;

endmodule

FILE: rtl/core/bog_cell.sv
// one quotient bit of the coordinate split, folding the bit into both offsets
module bog_cell import bog_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bog_stride_t stride_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  bog_item_t   item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output bog_item_t   item_o
);

  localparam int DW = IDX_W + SHIFT + 1;

  logic      valid_q;
  bog_item_t item_q, item_d;
  logic [DW-1:0] div;
  logic [DW-1:0] rem_ext;

  always_comb begin
    div     = DW'(stride_i.os) << SHIFT;
    rem_ext = DW'(item_i.rem);
    item_d  = item_i;
    if (rem_ext >= div) begin
      item_d.rem  = item_i.rem - div[IDX_W-1:0];
      item_d.loff = item_i.loff + (stride_i.ls << SHIFT);
      item_d.roff = item_i.roff + (stride_i.rs << SHIFT);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: rtl/core/bog_cfg.sv
// configuration registers and the stride sequencer that walks the axes
module bog_cfg import bog_pkg::*; #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output bog_stride_t       stride_o [MAX_RANK],
  output bog_status_t       status_o
);

  localparam int EB  = EXTENT_BITS;
  localparam int PW  = IDX_W + 1;
  localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int LW  = (PW > IDX_W + 1) ? PW : IDX_W + 1;
  localparam logic [CFG_W-1:0] EXT_RESET = {(CFG_W / 16){16'h0001}};
  localparam logic [PW-1:0] LIMIT = PW'(1) << IDX_W;
  localparam logic [LW-1:0] CAP = LW'(1) << IDX_W;

  function automatic logic [EB-1:0] field_of(input logic [CFG_W-1:0] pk,
                                             input logic [RANK_CW-1:0] ax);
    logic [16*EB+CFG_W-1:0] wide;
    begin
      wide = {{(16*EB){1'b0}}, pk};
      return wide[ax*EB +: EB];
    end
  endfunction

  function automatic logic [IDX_W:0] cap_of(input logic [PW-1:0] v);
    logic [LW-1:0] w;
    begin
      w = LW'(v);
      if (w > CAP) w = CAP;
      return w[IDX_W:0];
    end
  endfunction

  logic [RANK_W-1:0] out_rank_q, left_rank_q, right_rank_q;
  logic [CFG_W-1:0]  out_ext_q, left_ext_q, right_ext_q;
  logic              cfg_we;

  logic              busy_q, fault_q;
  logic [AXW-1:0]    ax_q;
  logic [PW-1:0]     op_q;
  logic [OFF_W-1:0]  lp_q, rp_q;
  bog_stride_t       stride_q [MAX_RANK];

  logic [RANK_CW-1:0] ar, orank, lrank, rrank, lpad, rpad, lk, rk;
  logic               used_o, used_l, used_r, rank_bad, ax_fault;
  logic [EB-1:0]      eo, el, er;
  logic [PW+EB-1:0]   prod;
  logic [PW-1:0]      op_n;
  bog_stride_t        st_n;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    ar     = RANK_CW'(ax_q);
    orank  = RANK_CW'(out_rank_q);
    lrank  = RANK_CW'(left_rank_q);
    rrank  = RANK_CW'(right_rank_q);
    lpad   = orank - lrank;
    rpad   = orank - rrank;
    lk     = ar - lpad;
    rk     = ar - rpad;
    used_o = ar < orank;
    used_l = used_o && (ar >= lpad);
    used_r = used_o && (ar >= rpad);
    eo     = field_of(out_ext_q, ar);
    el     = field_of(left_ext_q, lk);
    er     = field_of(right_ext_q, rk);
    prod   = op_q * eo;
    op_n   = (prod > (PW+EB)'(LIMIT)) ? LIMIT : prod[PW-1:0];
    rank_bad = (orank > RANK_CW'(MAX_RANK)) || (lrank > orank) || (rrank > orank);
    ax_fault = 1'b0;
    st_n.os = CAP[IDX_W:0];
    st_n.ls = '0;
    st_n.rs = '0;
    if (used_o) begin
      st_n.os = cap_of(op_q);
      if (eo == '0) ax_fault = 1'b1;
    end
    if (used_l) begin
      if (el != EB'(1)) st_n.ls = lp_q;
      if ((el == '0) || ((el != EB'(1)) && (el != eo))) ax_fault = 1'b1;
    end
    if (used_r) begin
      if (er != EB'(1)) st_n.rs = rp_q;
      if ((er == '0) || ((er != EB'(1)) && (er != eo))) ax_fault = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rank_q   <= '0;
      left_rank_q  <= '0;
      right_rank_q <= '0;
      out_ext_q    <= EXT_RESET;
      left_ext_q   <= EXT_RESET;
      right_ext_q  <= EXT_RESET;
      busy_q       <= 1'b1;
      fault_q      <= 1'b0;
      ax_q         <= AXW'(MAX_RANK - 1);
      op_q         <= PW'(1);
      lp_q         <= OFF_W'(1);
      rp_q         <= OFF_W'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_OUT_RANK:   out_rank_q   <= cfg_data_i[RANK_W-1:0];
        CFG_OUT_EXT:    out_ext_q    <= cfg_data_i;
        CFG_LEFT_RANK:  left_rank_q  <= cfg_data_i[RANK_W-1:0];
        CFG_LEFT_EXT:   left_ext_q   <= cfg_data_i;
        CFG_RIGHT_RANK: right_rank_q <= cfg_data_i[RANK_W-1:0];
        CFG_RIGHT_EXT:  right_ext_q  <= cfg_data_i;
        default: ;
      endcase
      busy_q  <= 1'b1;
      fault_q <= 1'b0;
      ax_q    <= AXW'(MAX_RANK - 1);
      op_q    <= PW'(1);
      lp_q    <= OFF_W'(1);
      rp_q    <= OFF_W'(1);
    end else if (busy_q) begin
      if (used_o) op_q <= op_n;
      if (used_l) lp_q <= lp_q * OFF_W'(el);
      if (used_r) rp_q <= rp_q * OFF_W'(er);
      if (ax_fault) fault_q <= 1'b1;
      if (ax_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        ax_q <= ax_q - AXW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we) begin
      stride_q[ax_q] <= st_n;
    end
  end

  assign stride_o       = stride_q;
  assign status_o.busy  = busy_q;
  assign status_o.fault = fault_q || rank_bad;
  assign status_o.limit = cap_of(op_q);

endmodule

FILE: rtl/core/bog_checker.sv
// port-level checks of the broadcast offset generator, bound to the top level
`include "broadcast_offset_generator_defines.svh"

module bog_checker import bog_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [OFF_W-1:0] lhs_off_o,
  input logic [OFF_W-1:0] rhs_off_o,
  input logic             fault_o
);

  // faulted transaction carries zero offsets
  `BOG_ASSERT_IMP(a_fault_zero, out_valid_o && fault_o, (lhs_off_o == '0) && (rhs_off_o == '0), "offsets not zero on fault")
  // strides are rebuilt after a register write, so input is held off
  `BOG_ASSERT_NXT(a_cfg_hold, cfg_valid_i && cfg_ready_o, !in_ready_o, "input taken during stride rebuild")
  // stalled result keeps its payload
  `BOG_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(lhs_off_o) && $stable(rhs_off_o) && $stable(fault_o), "stalled result changed")

endmodule

bind broadcast_offset_generator bog_checker u_bog_checker (.*);
